### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros used by the parser core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/asn1p_pkg.sv
// ----------------------------------------------------------------------------
// asn1p_pkg
// shared types and constants of the tlv stream parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asn1p_pkg;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_CONTENT = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DEPTH = 2'd1;
    localparam logic [1:0] ERR_LEN   = 2'd2;
    localparam logic [1:0] ERR_TAG   = 2'd3;

    localparam logic [2:0] PH_ID   = 3'd0;
    localparam logic [2:0] PH_TAG  = 3'd1;
    localparam logic [2:0] PH_LEN0 = 3'd2;
    localparam logic [2:0] PH_LENX = 3'd3;
    localparam logic [2:0] PH_BODY = 3'd4;

    // control from the parser to each stack cell
    typedef struct packed {
        logic        clear;
        logic [31:0] pos;
        logic [31:0] push_end;
        logic        push_indef;
    } asn1p_cell_ctl_t;

endpackage

### src/asn1_der_tlv_stream_parser_core.sv
// ----------------------------------------------------------------------------
// asn1_der_tlv_stream_parser_core
// asn.1 ber/der tlv stream parser, one byte per beat
// ----------------------------------------------------------------------------
// Takes one stream byte per beat and emits at most one record per byte: a
// header record once identifier and length are decoded, a content record per
// byte of a primitive item, or an error record. Nesting levels sit in a row of
// MAX_DEPTH level cells; every cell compares its end position against the
// stream position in parallel, and a priority cascade from the top of the
// stack finds how many levels close, so each byte is finished as it is taken.
// A new beat is taken every cycle unless a full output register is stalled;
// the result goes into a single output register which is refilled in the
// same cycle it is drained. No clearing pass after reset is needed.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module asn1_der_tlv_stream_parser_core
#(
    parameter int MAX_DEPTH    = 8,
    parameter int LENGTH_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: octet_string_nested
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // start_of_stream
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: item_class[1:0], tag_number[22:2], is_constructed[23],
    // content_length[55:24], is_indefinite[56], nest_depth[60:57],
    // content_value[68:61], levels_closed[72:69], error_code[74:73], pad
    output logic [79:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // record_kind
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int LW = $clog2(LENGTH_BYTES + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // config register
    logic osn_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            osn_reg <= 1'b1;
        else if (cfg_we)
            osn_reg <= cfg_wdata;
    end

    // parse state
    logic [2:0]    phase_reg, phase_next;
    logic [20:0]   tag_reg, tag_next;
    logic [1:0]    cls_reg, cls_next;
    logic          cons_reg, cons_next;
    logic [31:0]   len_reg, len_next;
    logic [LW-1:0] lleft_reg, lleft_next;
    logic [31:0]   pleft_reg, pleft_next;
    logic [31:0]   pos_reg, pos_next;
    logic [DW-1:0] open_reg, open_next;

    // output register
    logic        ovalid_reg;
    logic [79:0] odata_reg, odata_next;
    logic [1:0]  okind_reg, okind_next;
    logic        emit;

    logic accept;
    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // level cells
    asn1p_pkg::asn1p_cell_ctl_t ctl;
    logic [MAX_DEPTH-1:0] c_indef, c_reached, c_push;
    logic                 push;

    genvar g;
    generate
        for (g = 0; g < MAX_DEPTH; g++)
        begin : g_cell
            assign c_push[g] = accept && push && (open_reg == DW'(g)) && !ctl.clear;
            asn1p_level_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .push_here (c_push[g]),
                .indef     (c_indef[g]),
                .reached   (c_reached[g])
            );
        end
    endgenerate

    // effective state after optional start-of-stream clear
    logic [2:0]    ph;
    logic [20:0]   tg;
    logic [1:0]    cl;
    logic          cn;
    logic [31:0]   ln;
    logic [LW-1:0] lb;
    logic [31:0]   pb;
    logic [DW-1:0] op;
    logic [7:0]    b;

    // cascade of definite levels that are reached, from a given top
    function automatic logic [DW-1:0] cascade(input logic [DW-1:0] top,
                                              input logic [MAX_DEPTH-1:0] ind,
                                              input logic [MAX_DEPTH-1:0] rch);
        logic [DW-1:0] n;
        logic          go;
        n  = '0;
        go = 1'b1;
        for (int i = MAX_DEPTH - 1; i >= 0; i--)
        begin
            if (DW'(i) < top)
            begin
                if (go && !ind[i] && rch[i])
                    n = n + 1'b1;
                else
                    go = 1'b0;
            end
        end
        return n;
    endfunction

    logic [31:0]   hdr_len;
    logic          hdr_indef;
    logic [DW-1:0] closed;
    logic [1:0]    kind;
    logic [1:0]    err;
    logic          fail;
    logic          do_hdr;
    logic          nests;
    logic          eoc;
    logic [DW-1:0] top_after;
    logic [31:0]   rec_len;
    logic          rec_indef;
    logic          rec_cons;

    always_comb
    begin
        b  = s_axis_tdata;
        ph = s_axis_tuser ? asn1p_pkg::PH_ID : phase_reg;
        tg = s_axis_tuser ? '0 : tag_reg;
        cl = s_axis_tuser ? '0 : cls_reg;
        cn = s_axis_tuser ? 1'b0 : cons_reg;
        ln = s_axis_tuser ? '0 : len_reg;
        lb = s_axis_tuser ? '0 : lleft_reg;
        pb = s_axis_tuser ? '0 : pleft_reg;
        op = s_axis_tuser ? '0 : open_reg;

        pos_next   = (s_axis_tuser ? 32'd0 : pos_reg) + 32'd1;
        phase_next = ph;
        tag_next   = tg;
        cls_next   = cl;
        cons_next  = cn;
        len_next   = ln;
        lleft_next = lb;
        pleft_next = pb;
        open_next  = op;

        ctl.clear      = s_axis_tuser;
        ctl.pos        = pos_next;
        ctl.push_end   = '0;
        ctl.push_indef = 1'b0;
        push           = 1'b0;

        emit      = 1'b0;
        kind      = asn1p_pkg::KIND_HEADER;
        err       = asn1p_pkg::ERR_NONE;
        fail      = 1'b0;
        do_hdr    = 1'b0;
        hdr_len   = ln;
        hdr_indef = 1'b0;
        closed    = '0;
        rec_len   = ln;
        rec_indef = 1'b0;
        rec_cons  = cn;
        nests     = 1'b0;
        eoc       = 1'b0;
        top_after = op;

        case (ph)
            asn1p_pkg::PH_ID:
            begin
                cls_next  = b[7:6];
                cons_next = b[5];
                len_next  = '0;
                if (b[4:0] == 5'h1F)
                begin
                    tag_next   = '0;
                    phase_next = asn1p_pkg::PH_TAG;
                end
                else
                begin
                    tag_next   = {16'd0, b[4:0]};
                    phase_next = asn1p_pkg::PH_LEN0;
                end
            end
            asn1p_pkg::PH_TAG:
            begin
                if (tg[20:14] != '0)
                begin
                    fail = 1'b1;
                    err  = asn1p_pkg::ERR_TAG;
                end
                else
                begin
                    tag_next = {tg[13:0], b[6:0]};
                    if (!b[7])
                        phase_next = asn1p_pkg::PH_LEN0;
                end
            end
            asn1p_pkg::PH_LEN0:
            begin
                if (b[7])
                begin
                    if (b[6:0] == '0)
                    begin
                        do_hdr    = 1'b1;
                        hdr_indef = 1'b1;
                        hdr_len   = '0;
                    end
                    else if (32'(b[6:0]) > 32'(LENGTH_BYTES))
                    begin
                        fail = 1'b1;
                        err  = asn1p_pkg::ERR_LEN;
                    end
                    else
                    begin
                        len_next   = '0;
                        lleft_next = LW'(b[6:0]);
                        phase_next = asn1p_pkg::PH_LENX;
                    end
                end
                else
                begin
                    len_next = {24'd0, b};
                    do_hdr   = 1'b1;
                    hdr_len  = {24'd0, b};
                end
            end
            asn1p_pkg::PH_LENX:
            begin
                if (ln[31:24] != '0)
                begin
                    fail = 1'b1;
                    err  = asn1p_pkg::ERR_LEN;
                end
                else
                begin
                    len_next = {ln[23:0], b};
                    if (lb != '0)
                        lleft_next = lb - 1'b1;
                    if (lb <= LW'(1))
                    begin
                        do_hdr  = 1'b1;
                        hdr_len = {ln[23:0], b};
                    end
                end
            end
            asn1p_pkg::PH_BODY:
            begin
                emit      = 1'b1;
                kind      = asn1p_pkg::KIND_CONTENT;
                rec_cons  = 1'b0;
                if (pb != '0)
                    pleft_next = pb - 32'd1;
                if (pb <= 32'd1)
                begin
                    phase_next = asn1p_pkg::PH_ID;
                    closed     = cascade(op, c_indef, c_reached);
                    open_next  = op - closed;
                end
            end
            default:
            begin
                phase_next = asn1p_pkg::PH_ID;
            end
        endcase

        if (do_hdr)
        begin
            nests = cn || (osn_reg && cl == 2'd0 && tg == 21'd4);
            emit      = 1'b1;
            rec_len   = hdr_len;
            rec_indef = hdr_indef;
            if (!hdr_indef && hdr_len == '0)
            begin
                eoc = (cl == 2'd0) && !cn && (tg == '0) && (op != '0)
                      && c_indef[IW'(op - 1'b1)];
                top_after  = eoc ? op - 1'b1 : op;
                closed     = DW'(eoc) + cascade(top_after, c_indef, c_reached);
                open_next  = op - closed;
                phase_next = asn1p_pkg::PH_ID;
            end
            else if (nests)
            begin
                if (op >= DW'(MAX_DEPTH))
                begin
                    fail = 1'b1;
                    err  = asn1p_pkg::ERR_DEPTH;
                end
                else
                begin
                    push           = 1'b1;
                    ctl.push_end   = pos_next + hdr_len;
                    ctl.push_indef = hdr_indef;
                    open_next      = op + 1'b1;
                    phase_next     = asn1p_pkg::PH_ID;
                end
            end
            else if (hdr_indef)
            begin
                closed     = cascade(op, c_indef, c_reached);
                open_next  = op - closed;
                phase_next = asn1p_pkg::PH_ID;
            end
            else
            begin
                pleft_next = hdr_len;
                phase_next = asn1p_pkg::PH_BODY;
            end
        end

        // error record carries held fields (the header length on a depth error) then clears the parse state
        if (fail)
        begin
            emit      = 1'b1;
            kind      = asn1p_pkg::KIND_ERROR;
            rec_len   = ln;
            rec_indef = 1'b0;
            rec_cons  = cn;
            closed    = '0;
            push      = 1'b0;
            if (err == asn1p_pkg::ERR_DEPTH)
            begin
                rec_indef = hdr_indef;
                rec_len   = hdr_indef ? 32'd0 : hdr_len;
            end
            phase_next = asn1p_pkg::PH_ID;
            tag_next   = '0;
            cls_next   = '0;
            cons_next  = 1'b0;
            len_next   = '0;
            lleft_next = '0;
            pleft_next = '0;
            pos_next   = '0;
            open_next  = '0;
        end

        okind_next = kind;
        odata_next = '0;
        odata_next[1:0]   = cl;
        odata_next[22:2]  = tg;
        odata_next[23]    = rec_cons;
        odata_next[55:24] = rec_len;
        odata_next[56]    = rec_indef;
        odata_next[60:57] = 4'(op);
        odata_next[68:61] = (kind == asn1p_pkg::KIND_HEADER) ? 8'd0 : b;
        odata_next[72:69] = 4'(closed);
        odata_next[74:73] = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= asn1p_pkg::PH_ID;
            tag_reg    <= '0;
            cls_reg    <= '0;
            cons_reg   <= 1'b0;
            len_reg    <= '0;
            lleft_reg  <= '0;
            pleft_reg  <= '0;
            pos_reg    <= '0;
            open_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                tag_reg   <= tag_next;
                cls_reg   <= cls_next;
                cons_reg  <= cons_next;
                len_reg   <= len_next;
                lleft_reg <= lleft_next;
                pleft_reg <= pleft_next;
                pos_reg   <= pos_next;
                open_reg  <= open_next;
            end
            if (accept)
                ovalid_reg <= emit;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            odata_reg <= odata_next;
            okind_reg <= okind_next;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = okind_reg;

    // stack never holds more than MAX_DEPTH levels
    `ASSERT_ALWAYS(a_open_bound, clk, rst_n, open_reg <= DW'(MAX_DEPTH),
        "open level count beyond stack depth")
    // an error record leaves the parse state cleared
    `ASSERT_NEXT(a_err_clear, clk, rst_n, accept && fail,
        open_reg == '0 && phase_reg == asn1p_pkg::PH_ID, "error did not clear state")
    // a stalled output holds its record
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled record changed")

endmodule

### src/asn1p_level_cell.sv
// ----------------------------------------------------------------------------
// asn1p_level_cell
// one nesting level: end position, indefinite flag and its close tests
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asn1p_level_cell
(
    input  logic                      clk,
    input  asn1p_pkg::asn1p_cell_ctl_t ctl,
    input  logic                      push_here,
    output logic                      indef,
    output logic                      reached
);

    logic [31:0] end_reg;
    logic        indef_reg;

    // payload only, no reset needed for contents
    always_ff @(posedge clk)
    begin
        if (push_here)
        begin
            end_reg   <= ctl.push_end;
            indef_reg <= ctl.push_indef;
        end
    end

    assign indef   = indef_reg;
    // unsigned compare against the post-increment position
    assign reached = (ctl.pos >= end_reg);

endmodule
